>>> sv/assert_macros.svh
// Assertion helpers for the chunky-to-planar converter.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define C2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define C2P_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/c2p_pkg.sv
`timescale 1ns / 1ps
package c2p_pkg;

  localparam int MAX_PLANES_DEF  = 24;
  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_LINES       = 4096;
  localparam int WORD_W          = 16;

  localparam int MODE_W  = 3;
  localparam int CNT13_W = 13;
  localparam int PLANE_W = 5;
  localparam int LINE_W  = 12;
  localparam int WCOL_W  = 8;
  localparam int FILL_W  = 5;
  localparam int SHIFT_W = 4;
  localparam int PIX_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT      = 2'd2;

  localparam logic [MODE_W-1:0]  MODE_2BIT  = 3'd0;
  localparam logic [MODE_W-1:0]  MODE_4BIT  = 3'd1;
  localparam logic [MODE_W-1:0]  MODE_8BIT  = 3'd2;
  localparam logic [MODE_W-1:0]  MODE_16BIT = 3'd3;

  localparam logic [MODE_W-1:0]  PIXEL_MODE_RST = MODE_8BIT;
  localparam logic [CNT13_W-1:0] PPL_RST        = 13'd640;
  localparam logic [CNT13_W-1:0] LINES_RST      = 13'd480;

  // Control handed from the sequencer to every plane cell.
  typedef struct packed {
    logic               load;
    logic               drain;
    logic [PLANE_W-1:0] planes;
  } cell_ctl_t;

  // Number of planes a mode uses; undefined codes act as 24-bit pixels.
  function automatic logic [5:0] depth_of_mode(input logic [MODE_W-1:0] mode);
    logic [5:0] d;
    unique case (mode)
      MODE_2BIT:  d = 6'd2;
      MODE_4BIT:  d = 6'd4;
      MODE_8BIT:  d = 6'd8;
      MODE_16BIT: d = 6'd16;
      default:    d = 6'd24;
    endcase
    return d;
  endfunction

endpackage

>>> sv/c2p_cell.sv
`timescale 1ns / 1ps
module c2p_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  c2p_pkg::cell_ctl_t        ctl,
  input  logic [c2p_pkg::PIX_W-1:0] pixel,
  input  logic [c2p_pkg::WORD_W-1:0] next_word,
  output logic [c2p_pkg::WORD_W-1:0] word
);
  import c2p_pkg::*;

  logic [WORD_W-1:0]  word_r;
  logic [WORD_W-1:0]  word_nxt;
  logic               in_use;
  logic               next_in_use;
  logic [PLANE_W-1:0] bit_sel;

  assign in_use      = 6'(IDX) < {1'b0, ctl.planes};
  assign next_in_use = 6'(IDX + 1) < {1'b0, ctl.planes};
  // Plane 0 takes the most significant used pixel bit.
  assign bit_sel     = PLANE_W'(ctl.planes - 5'd1 - PLANE_W'(IDX));

  always_comb begin
    word_nxt = word_r;
    if (ctl.load) begin
      if (in_use) begin
        word_nxt = {word_r[WORD_W-2:0], pixel[bit_sel]};
      end
    end else if (ctl.drain) begin
      // Words move one cell toward the output; unused cells fill with zeros,
      // so the whole row is clear once the last plane has left.
      word_nxt = next_in_use ? next_word : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

>>> sv/chunky_to_planar_converter_unit.sv
// The plane words of a group start in the cycle after the request that closes it.
// Pixels are taken one per cycle while no group is emitted; an emitted group's plane words leave
// one per cycle unless out_stall holds them, since every word leaves through the first cell of
// the plane chain, and in_stall holds new pixels until the group's last word has left.
// Reset (synchronous, rst_n low): counters, output valid and all plane shifters clear,
// and the configuration registers take their reset values.
`timescale 1ns / 1ps
module chunky_to_planar_converter_unit #(
  parameter int MAX_PLANES = c2p_pkg::MAX_PLANES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [c2p_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [c2p_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [c2p_pkg::PIX_W-1:0]      in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [c2p_pkg::PLANE_W-1:0]    out_plane_index,
  output logic [c2p_pkg::WORD_W-1:0]     out_plane_word,
  output logic [c2p_pkg::LINE_W-1:0]     out_line_index,
  output logic [c2p_pkg::WCOL_W-1:0]     out_word_column,
  output logic                           out_last_of_group,
  output logic                           out_end_of_image
);
  import c2p_pkg::*;

  `include "assert_macros.svh"

  localparam logic [5:0] MaxPl = 6'(MAX_PLANES);

  logic [MODE_W-1:0]  pixel_mode_r, pixel_mode_nxt;
  logic [CNT13_W-1:0] ppl_r, ppl_nxt;
  logic [CNT13_W-1:0] lines_r, lines_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [CNT13_W-1:0] col_r, col_nxt;
  logic [WCOL_W-1:0]  widx_r, widx_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               drain_r, drain_nxt;
  logic [PLANE_W-1:0] pcnt_r, pcnt_nxt;
  logic [LINE_W-1:0]  em_line_r, em_line_nxt;
  logic [WCOL_W-1:0]  em_col_r, em_col_nxt;
  logic               em_eoi_r, em_eoi_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;

  logic               in_acc, out_acc;
  logic [5:0]         depth6, planes6;
  logic [PLANE_W-1:0] planes;
  logic [FILL_W-1:0]  fill_inc;
  logic [CNT13_W-1:0] col_inc;
  logic [CNT13_W-1:0] eff_ppl, eff_lines;
  logic [CNT13_W-1:0] line_inc;
  logic               line_end, image_end, emit, last_word;
  logic [FILL_W-1:0]  shift_wide;

  cell_ctl_t          ctl;
  logic [WORD_W-1:0]  cell_word [MAX_PLANES];

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign depth6  = depth_of_mode(pixel_mode_r);
  assign planes6 = (depth6 > MaxPl) ? MaxPl : depth6;
  assign planes  = planes6[PLANE_W-1:0];

  assign fill_inc = fill_r + 5'd1;
  assign col_inc  = col_r + 13'd1;
  assign line_inc = {1'b0, line_r} + 13'd1;

  assign eff_ppl = (ppl_r == '0) ? 13'd1 :
                   (ppl_r > 13'(MAX_LINE_PIXELS)) ? 13'(MAX_LINE_PIXELS) : ppl_r;
  assign eff_lines = (lines_r == '0) ? 13'd1 :
                     (lines_r > 13'(MAX_LINES)) ? 13'(MAX_LINES) : lines_r;

  // A line ends when the column reaches or passes the line length, so a
  // shortened line length still closes the current line.
  assign line_end   = col_inc >= eff_ppl;
  assign image_end  = line_end && (line_inc >= eff_lines);
  assign emit       = (fill_inc >= 5'(WORD_W)) || line_end;
  assign shift_wide = (fill_inc >= 5'(WORD_W)) ? 5'd0 : 5'(WORD_W) - fill_inc;
  assign last_word  = pcnt_r == (planes - 5'd1);

  always_comb begin
    pixel_mode_nxt = pixel_mode_r;
    ppl_nxt        = ppl_r;
    lines_nxt      = lines_r;
    fill_nxt       = fill_r;
    col_nxt        = col_r;
    widx_nxt       = widx_r;
    line_nxt       = line_r;
    drain_nxt      = drain_r;
    pcnt_nxt       = pcnt_r;
    em_line_nxt    = em_line_r;
    em_col_nxt     = em_col_r;
    em_eoi_nxt     = em_eoi_r;
    shift_nxt      = shift_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_MODE:      pixel_mode_nxt = cfg_wdata[MODE_W-1:0];
        REG_PIXELS_PER_LINE: ppl_nxt        = cfg_wdata;
        REG_LINE_COUNT:      lines_nxt      = cfg_wdata;
        default:             ;
      endcase
    end

    if (in_acc) begin
      if (emit) begin
        fill_nxt    = '0;
        drain_nxt   = 1'b1;
        pcnt_nxt    = '0;
        em_line_nxt = line_r;
        em_col_nxt  = widx_r;
        em_eoi_nxt  = image_end;
        shift_nxt   = shift_wide[SHIFT_W-1:0];
        if (line_end) begin
          col_nxt  = '0;
          widx_nxt = '0;
          line_nxt = image_end ? '0 : line_inc[LINE_W-1:0];
        end else begin
          col_nxt  = col_inc;
          widx_nxt = widx_r + 8'd1;
        end
      end else begin
        fill_nxt = fill_inc;
        col_nxt  = col_inc;
      end
    end

    if (out_acc) begin
      pcnt_nxt = pcnt_r + 5'd1;
      if (last_word) begin
        drain_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= PIXEL_MODE_RST;
      ppl_r        <= PPL_RST;
      lines_r      <= LINES_RST;
      fill_r       <= '0;
      col_r        <= '0;
      widx_r       <= '0;
      line_r       <= '0;
      drain_r      <= 1'b0;
      pcnt_r       <= '0;
    end else begin
      pixel_mode_r <= pixel_mode_nxt;
      ppl_r        <= ppl_nxt;
      lines_r      <= lines_nxt;
      fill_r       <= fill_nxt;
      col_r        <= col_nxt;
      widx_r       <= widx_nxt;
      line_r       <= line_nxt;
      drain_r      <= drain_nxt;
      pcnt_r       <= pcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_line_r <= em_line_nxt;
    em_col_r  <= em_col_nxt;
    em_eoi_r  <= em_eoi_nxt;
    shift_r   <= shift_nxt;
  end

  assign ctl.load   = in_acc;
  assign ctl.drain  = out_acc;
  assign ctl.planes = planes;

  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
    logic [WORD_W-1:0] nb_word;
    if (i == MAX_PLANES - 1) begin : g_tail
      assign nb_word = '0;
    end else begin : g_link
      assign nb_word = cell_word[i+1];
    end
    c2p_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .pixel     (in_pixel_value),
      .next_word (nb_word),
      .word      (cell_word[i])
    );
  end

  assign in_stall          = drain_r;
  assign out_valid         = drain_r;
  assign out_plane_index   = pcnt_r;
  // A partial word is left-justified as it leaves the chain.
  assign out_plane_word    = cell_word[0] << shift_r;
  assign out_line_index    = em_line_r;
  assign out_word_column   = em_col_r;
  assign out_last_of_group = last_word;
  assign out_end_of_image  = em_eoi_r;

  `C2P_ASSERT(a_plane_in_range, out_valid |-> (out_plane_index < planes), "plane index beyond used planes")
  `C2P_ASSERT(a_run_ends, (out_acc && out_last_of_group) |=> !out_valid, "run continued after its last word")
  `C2P_ASSERT(a_plane_steps, (out_acc && !out_last_of_group) |=> (out_valid && (out_plane_index == $past(out_plane_index) + 5'd1)), "plane order broken within a run")
  `C2P_ASSERT_NEVER(a_no_overlap, in_acc && out_valid, "pixel taken while plane words are pending")

endmodule
